@@ rtl/mcr_pkg.sv @@
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // default geometry
  localparam int COORD_BITS_DEF  = 12;
  localparam int RADIUS_BITS_DEF = 11;

  // step queue between the front and back parts
  localparam int STEP_FIFO_DEPTH = 2;

  // mirrored points per octant step
  localparam int POINTS_PER_STEP = 8;
  localparam int POINT_IDX_BITS  = $clog2(POINTS_PER_STEP);

  // item kinds
  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_t;

endpackage

@@ rtl/mcr_front.sv @@
// ----------------------------------------------------------------------------
// mcr_front
// Accepts start and advance items, holds the octant state and the decision
// term, and hands each plotted step to the step queue.
// ----------------------------------------------------------------------------
module mcr_front import mcr_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   kind,
  input  logic [COORD_BITS-1:0]  center_x,
  input  logic [COORD_BITS-1:0]  center_y,
  input  logic [RADIUS_BITS-1:0] radius,
  output logic                   job_push,
  input  logic                   job_room,
  output logic [COORD_BITS-1:0]  job_cx,
  output logic [COORD_BITS-1:0]  job_cy,
  output logic [RADIUS_BITS-1:0] job_x,
  output logic [RADIUS_BITS-1:0] job_y,
  output logic                   job_done
);

  localparam int DW = RADIUS_BITS + 3;
  localparam logic signed [DW-1:0] D_ONE      = DW'(1);
  localparam logic signed [DW-1:0] D_INC_EAST = DW'(3);
  localparam logic signed [DW-1:0] D_INC_DIAG = DW'(5);

  logic                   active;
  logic [RADIUS_BITS-1:0] step_x;
  logic [RADIUS_BITS-1:0] step_y;
  logic signed [DW-1:0]   decision;
  logic [COORD_BITS-1:0]  stored_cx;
  logic [COORD_BITS-1:0]  stored_cy;

  logic                   accept;
  logic                   is_start;
  logic signed [DW-1:0]   x_ext;
  logic signed [DW-1:0]   y_ext;
  logic signed [DW-1:0]   decision_next;
  logic [RADIUS_BITS:0]   x_plus;
  logic [RADIUS_BITS-1:0] y_next;
  logic                   done_next;

  // transfer and classification
  assign in_ready = job_room;
  assign accept   = in_valid && in_ready;
  assign is_start = (kind_t'(kind) == KIND_START);
  assign job_push = accept && !is_start && active;

  // midpoint update
  assign x_ext  = signed'(DW'(step_x));
  assign y_ext  = signed'(DW'(step_y));
  assign x_plus = {1'b0, step_x} + (RADIUS_BITS+1)'(1);

  always_comb begin
    if (decision[DW-1]) begin
      decision_next = decision + (x_ext <<< 1) + D_INC_EAST;
      y_next        = step_y;
    end else begin
      decision_next = decision + ((x_ext - y_ext) <<< 1) + D_INC_DIAG;
      y_next        = step_y - RADIUS_BITS'(1);
    end
  end

  assign done_next = (x_plus >= {1'b0, y_next});

  // step handed to the back part uses the state before the update
  assign job_cx   = stored_cx;
  assign job_cy   = stored_cy;
  assign job_x    = step_x;
  assign job_y    = step_y;
  assign job_done = done_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept && is_start) begin
      active <= (radius != '0);
    end else if (job_push && done_next) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_start) begin
      stored_cx <= center_x;
      stored_cy <= center_y;
      step_x    <= '0;
      step_y    <= radius;
      decision  <= D_ONE - signed'(DW'(radius));
    end else if (job_push) begin
      step_x    <= x_plus[RADIUS_BITS-1:0];
      step_y    <= y_next;
      decision  <= decision_next;
    end
  end

endmodule

@@ rtl/mcr_fifo.sv @@
// ----------------------------------------------------------------------------
// mcr_fifo
// Small register queue of octant steps between the front and back parts.
// ----------------------------------------------------------------------------
module mcr_fifo import mcr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = STEP_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             room,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign room     = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_push  = push && room;
  assign do_pop   = pop && rd_valid;
  assign rd_data  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ rtl/mcr_back.sv @@
// ----------------------------------------------------------------------------
// mcr_back
// Takes one octant step at a time and sends its eight mirrored points, one
// per cycle while out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module mcr_back import mcr_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  logic [COORD_BITS-1:0]         job_cx,
  input  logic [COORD_BITS-1:0]         job_cy,
  input  logic [RADIUS_BITS-1:0]        job_x,
  input  logic [RADIUS_BITS-1:0]        job_y,
  input  logic                          job_done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS+1:0]  pixel_x,
  output logic signed [COORD_BITS+1:0]  pixel_y,
  output logic                          last_of_step,
  output logic                          circle_done
);

  localparam int OW = COORD_BITS + 2;

  logic                      busy;
  logic [POINT_IDX_BITS-1:0] idx;
  logic [COORD_BITS-1:0]     cur_cx;
  logic [COORD_BITS-1:0]     cur_cy;
  logic [RADIUS_BITS-1:0]    cur_x;
  logic [RADIUS_BITS-1:0]    cur_y;
  logic                      cur_done;

  logic                      load_out;
  logic                      last_point;
  logic [RADIUS_BITS-1:0]    off_a;
  logic [RADIUS_BITS-1:0]    off_b;
  logic [OW-1:0]             base_x;
  logic [OW-1:0]             base_y;
  logic [OW-1:0]             ext_a;
  logic [OW-1:0]             ext_b;
  logic [OW-1:0]             point_x;
  logic [OW-1:0]             point_y;

  assign load_out   = busy && (!out_valid || out_ready);
  assign last_point = (idx == POINT_IDX_BITS'(POINTS_PER_STEP-1));
  assign job_ready  = !busy || (load_out && last_point);

  // point index: bit 2 swaps the axes, bit 1 mirrors y, bit 0 mirrors x
  always_comb begin
    off_a   = idx[2] ? cur_y : cur_x;
    off_b   = idx[2] ? cur_x : cur_y;
    base_x  = OW'(cur_cx);
    base_y  = OW'(cur_cy);
    ext_a   = OW'(off_a);
    ext_b   = OW'(off_b);
    point_x = idx[0] ? (base_x - ext_a) : (base_x + ext_a);
    point_y = idx[1] ? (base_y - ext_b) : (base_y + ext_b);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (job_ready) begin
        busy <= job_valid;
        idx  <= '0;
      end else if (load_out) begin
        idx  <= idx + POINT_IDX_BITS'(1);
      end
    end
  end

  // current step
  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      cur_cx   <= job_cx;
      cur_cy   <= job_cy;
      cur_x    <= job_x;
      cur_y    <= job_y;
      cur_done <= job_done;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      pixel_x      <= signed'(point_x);
      pixel_y      <= signed'(point_y);
      last_of_step <= last_point;
      circle_done  <= last_point && cur_done;
    end
  end

endmodule

@@ rtl/midpoint_circle_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top
// Midpoint circle generator with eight-way symmetry.
// ----------------------------------------------------------------------------
// A start item (kind 0) loads the center and radius and sends nothing; a
// zero radius leaves the block idle. Each advance item (kind 1) on an
// active circle sends the eight mirrored points of the current octant
// point, one per cycle while out_ready is high, from the single point
// generator in the back part; advances while idle send nothing.
// The front part updates the decision term in the cycle an item transfers
// and queues the step, so new items are taken while earlier points are
// still leaving, as long as the two-entry step queue has room. The eighth
// point of every step has last_of_step set, and the eighth point of the
// final step also has circle_done set. The diagonal point x==y is not
// plotted, and the duplicate points at x==0 are all sent.
module midpoint_circle_rasterizer_top import mcr_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          kind,
  input  logic [COORD_BITS-1:0]         center_x,
  input  logic [COORD_BITS-1:0]         center_y,
  input  logic [RADIUS_BITS-1:0]        radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS+1:0]  pixel_x,
  output logic signed [COORD_BITS+1:0]  pixel_y,
  output logic                          last_of_step,
  output logic                          circle_done
);

  localparam int JOB_W = 2*COORD_BITS + 2*RADIUS_BITS + 1;

  logic                   job_push;
  logic                   job_room;
  logic [COORD_BITS-1:0]  f_cx;
  logic [COORD_BITS-1:0]  f_cy;
  logic [RADIUS_BITS-1:0] f_x;
  logic [RADIUS_BITS-1:0] f_y;
  logic                   f_done;
  logic [JOB_W-1:0]       q_wr;
  logic [JOB_W-1:0]       q_rd;
  logic                   q_valid;
  logic                   q_pop;
  logic [COORD_BITS-1:0]  b_cx;
  logic [COORD_BITS-1:0]  b_cy;
  logic [RADIUS_BITS-1:0] b_x;
  logic [RADIUS_BITS-1:0] b_y;
  logic                   b_done;

  // front: item classification and octant state
  mcr_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .job_push (job_push),
    .job_room (job_room),
    .job_cx   (f_cx),
    .job_cy   (f_cy),
    .job_x    (f_x),
    .job_y    (f_y),
    .job_done (f_done)
  );

  // step queue
  assign q_wr = {f_cx, f_cy, f_x, f_y, f_done};

  mcr_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (STEP_FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .room     (job_room),
    .wr_data  (q_wr),
    .rd_valid (q_valid),
    .pop      (q_pop),
    .rd_data  (q_rd)
  );

  assign {b_cx, b_cy, b_x, b_y, b_done} = q_rd;

  // back: point generation and output stage
  mcr_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (q_valid),
    .job_ready    (q_pop),
    .job_cx       (b_cx),
    .job_cy       (b_cy),
    .job_x        (b_x),
    .job_y        (b_y),
    .job_done     (b_done),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .last_of_step (last_of_step),
    .circle_done  (circle_done)
  );

`ifndef ASSERT_OFF
  // circle end only on the closing point of a step
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && circle_done) |-> last_of_step)
    else $error("circle_done without last_of_step");

  // points of one step leave without gaps
  a_step_contiguous: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_step) |=> out_valid)
    else $error("gap inside a step");

  // a step is taken under a stalled output only by an idle back part
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_pop && out_valid && !out_ready) |-> !u_back.busy)
    else $error("step taken while output stalled");
`endif

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the midpoint circle rasterizer. Start and advance
// items go in through a bursty sender while a stalling receiver drains the
// mirrored points. Each point is checked against an in-bench octant stepper
// that tracks the center, the octant point and the decision term.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mcr_pkg::*;

  localparam int CW        = COORD_BITS_DEF;
  localparam int RW        = RADIUS_BITS_DEF;
  localparam int OW        = CW + 2;
  localparam int CMAX      = (1 << CW) - 1;
  localparam int RMAX      = (1 << RW) - 1;
  localparam int N_ITEMS   = 270;
  localparam int HOLD_LEN  = 300;
  localparam int LIMIT     = 400000;

  typedef struct {
    logic signed [OW-1:0] px;
    logic signed [OW-1:0] py;
    logic                 last;
    logic                 done;
  } point_t;

  // octant stepper and queue of points still owed by the block
  class circle_scoreboard;
    point_t       owed_q[$];
    bit [RW-1:0]  oct_x;
    bit [RW-1:0]  oct_y;
    int           decision;
    bit [CW-1:0]  org_x;
    bit [CW-1:0]  org_y;
    bit           active;
    int           errors;

    function new();
      oct_x    = '0;
      oct_y    = '0;
      decision = 0;
      org_x    = '0;
      org_y    = '0;
      active   = 1'b0;
      errors   = 0;
    endfunction

    function void owe(int px, int py, bit last, bit done);
      point_t p;
      p.px   = px[OW-1:0];
      p.py   = py[OW-1:0];
      p.last = last;
      p.done = done;
      owed_q.push_back(p);
    endfunction

    // one accepted item: a start loads, an advance steps the octant point
    function void note_item(kind_t k, bit [CW-1:0] cx, bit [CW-1:0] cy,
                            bit [RW-1:0] r);
      int x, y, ox, oy;
      bit done;
      if (k == KIND_START) begin
        org_x    = cx;
        org_y    = cy;
        oct_x    = '0;
        oct_y    = r;
        decision = 1 - int'(r);
        active   = (r != 0);
        return;
      end
      if (!active) return;
      ox = int'(org_x);
      oy = int'(org_y);
      x  = int'(oct_x);
      y  = int'(oct_y);
      if (decision < 0) begin
        decision += 2 * x + 3;
      end else begin
        decision += 2 * (x - y) + 5;
        oct_y = RW'(y - 1);
      end
      oct_x = RW'(x + 1);
      done  = (oct_x >= oct_y);
      if (done) active = 1'b0;
      owe(ox + x, oy + y, 1'b0, 1'b0);
      owe(ox - x, oy + y, 1'b0, 1'b0);
      owe(ox + x, oy - y, 1'b0, 1'b0);
      owe(ox - x, oy - y, 1'b0, 1'b0);
      owe(ox + y, oy + x, 1'b0, 1'b0);
      owe(ox - y, oy + x, 1'b0, 1'b0);
      owe(ox + y, oy - x, 1'b0, 1'b0);
      owe(ox - y, oy - x, 1'b1, done);
    endfunction

    function void flag(string name, int exp, int act);
      errors++;
      $error("%s: expected %0d, got %0d", name, exp, act);
    endfunction

    // one transferred point against the oldest owed one
    function void check_point(logic signed [OW-1:0] px, logic signed [OW-1:0] py,
                              logic last, logic done);
      point_t p;
      if (owed_q.size() == 0) begin
        errors++;
        $error("unexpected point (%0d,%0d) with nothing owed", px, py);
        return;
      end
      p = owed_q.pop_front();
      if (px !== p.px) flag("pixel_x", p.px, px);
      if (py !== p.py) flag("pixel_y", p.py, py);
      if (last !== p.last) flag("last_of_step", p.last, last);
      if (done !== p.done) flag("circle_done", p.done, done);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 kind = KIND_START;
  logic [CW-1:0]        center_x = '0;
  logic [CW-1:0]        center_y = '0;
  logic [RW-1:0]        radius = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [OW-1:0] pixel_x;
  logic signed [OW-1:0] pixel_y;
  logic                 last_of_step;
  logic                 circle_done;

  circle_scoreboard sb;
  int  cycles = 0;
  int  counted = 0;
  int  burst_left = 0;
  bit  no_gaps = 1'b0;
  bit  hold_req = 1'b0;

  midpoint_circle_rasterizer_top #(
    .COORD_BITS (CW),
    .RADIUS_BITS(RW)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .last_of_step(last_of_step),
    .circle_done (circle_done)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // point monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_point(pixel_x, pixel_y, last_of_step, circle_done);
  end

  // receiver: stall pattern changes mode now and then, plus one long hold-off
  initial begin
    int mode;
    int mode_left;
    int hold_cnt;
    mode      = 0;
    mode_left = 0;
    hold_cnt  = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_LEN;
        out_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CW'(CMAX);
      default: return CW'($urandom_range(0, CMAX));
    endcase
  endfunction

  // one item transfer; called at a falling edge, returns at a falling edge
  task automatic send(kind_t k, logic [CW-1:0] cx, logic [CW-1:0] cy,
                      logic [RW-1:0] r);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    if (k == KIND_START || sb.active) counted++;
    in_valid <= 1'b1;
    kind     <= k;
    center_x <= cx;
    center_y <= cy;
    radius   <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_item(k, cx, cy, r);
    @(negedge clk);
  endtask

  // advance with junk in the unused fields
  task automatic advance();
    send(KIND_ADVANCE, pick_coord(), pick_coord(), RW'($urandom_range(0, RMAX)));
  endtask

  initial begin
    logic [RW-1:0] r;
    int n_adv;
    int i;
    sb = new();

    // reset
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle advance, zero radius, unit circle at the origin
    advance();
    send(KIND_START, '0, '0, '0);
    advance();
    send(KIND_START, '0, '0, RW'(1));
    advance();
    advance();
    // largest center and radius, then a start that drops the running circle
    send(KIND_START, CW'(CMAX), CW'(CMAX), RW'(RMAX));
    repeat (3) advance();
    send(KIND_START, CW'(CMAX), '0, RW'(3));
    repeat (3) advance();
    send(KIND_START, '0, CW'(CMAX), RW'(RMAX));
    advance();
    send(KIND_START, CW'(CMAX / 2 + 1), CW'(CMAX / 2 + 1), RW'(5));
    repeat (5) advance();

    // input backs up behind a long receiver hold-off
    counted  = 0;
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    send(KIND_START, pick_coord(), pick_coord(), RW'(40));
    repeat (12) advance();
    no_gaps = 1'b0;

    // random: mostly whole or partial circles, some noise
    while (counted < N_ITEMS) begin
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 9))
          0:       r = '0;
          1, 2:    r = RW'($urandom_range(41, RMAX));
          default: r = RW'($urandom_range(1, 40));
        endcase
        send(KIND_START, pick_coord(), pick_coord(), r);
        n_adv = (r > 40) ? $urandom_range(1, 10) : 2000;
        if ($urandom_range(0, 4) == 0) n_adv = $urandom_range(0, 8);
        for (i = 0; i < n_adv && sb.active; i++) advance();
        repeat ($urandom_range(0, 2)) advance();
      end else begin
        repeat ($urandom_range(1, 4))
          send(kind_t'($urandom_range(0, 1)), pick_coord(), pick_coord(),
               RW'($urandom_range(0, RMAX)));
      end
    end
    in_valid <= 1'b0;

    // drain, then let a late stray point show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    if (sb.pending() != 0) begin
      sb.errors++;
      $error("%0d expected points never arrived", sb.pending());
    end
    if (sb.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mcr_pkg.sv
rtl/mcr_front.sv
rtl/mcr_fifo.sv
rtl/mcr_back.sv
rtl/midpoint_circle_rasterizer_top.sv
bench/tb_top.sv
